[design/ils_pkg.sv]
package ils_pkg;

  // Default sizing
  localparam int unsigned CAPACITY_DEF   = 64;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed port field widths
  localparam int unsigned REQ_W      = 3;
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned DATA_OUT_W = 32;
  localparam int unsigned POS_W      = 6;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned COUNT_W    = 7;

  // Request kinds
  typedef enum logic [REQ_W-1:0] {
    REQ_APPEND = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_REMOVE = 3'd2,
    REQ_READ   = 3'd3,
    REQ_FIND   = 3'd4
  } req_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

endpackage

[design/ils_mem.sv]
module ils_mem
  import ils_pkg::*;
#(
  parameter int unsigned DEPTH = CAPACITY_DEF,
  parameter int unsigned WIDTH = DATA_WIDTH_DEF,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/indexed_list_store_top.sv]
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | req_type_i, index_i, value_i
// out     | output    | out_valid_o/out_stall_i | data_o, position_o, found_o, status_o, count_o
//
// One request at a time; in_stall_o stays high from accept until the result
// is moved into the output register, and is low in the cycle after that.
// A walk reads the entries it covers, one read per cycle, and find stops it on a match.
// Append, insert at the end and find on an empty list pass through the walk with no read;
// errors and unknown kinds skip the walk and go straight to the hold state.
// Reset clears control state and entry count; store contents are undefined until written.
// A stalled result sits in the output register while the next request is taken.
module indexed_list_store_top
  import ils_pkg::*;
#(
  parameter int unsigned CAPACITY   = CAPACITY_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [REQ_W-1:0]      req_type_i,
  input  logic [IDX_W-1:0]      index_i,
  input  logic [VALUE_W-1:0]    value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [DATA_OUT_W-1:0] data_o,
  output logic [POS_W-1:0]      position_o,
  output logic                  found_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [COUNT_W-1:0]    count_o
);

  localparam int unsigned AW   = $clog2(CAPACITY);
  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned CMPW = (CW > IDX_W) ? CW : IDX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_HOLD = 2'd2;

  // Control state
  logic [1:0]            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  pend_q, pend_d;
  logic                  out_valid_q, out_valid_d;
  req_e                  kind_q, kind_d;

  // Walk and request payload
  logic [AW-1:0]         idx_q, idx_d;
  logic [AW-1:0]         walk_q, walk_d;
  logic [CW-1:0]         left_q, left_d;
  logic [AW-1:0]         pend_addr_q, pend_addr_d;
  logic [DATA_WIDTH-1:0] val_q, val_d;

  // Pending result and output register
  logic [DATA_OUT_W-1:0] res_data_q, res_data_d;
  logic [POS_W-1:0]      res_pos_q, res_pos_d;
  logic                  res_found_q, res_found_d;
  status_e               res_status_q, res_status_d;
  logic [DATA_OUT_W-1:0] out_data_q, out_data_d;
  logic [POS_W-1:0]      out_pos_q, out_pos_d;
  logic                  out_found_q, out_found_d;
  logic [STATUS_W-1:0]   out_status_q, out_status_d;
  logic [COUNT_W-1:0]    out_count_q, out_count_d;

  // Store ports
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  logic                  accept;
  logic                  full;
  logic [CMPW-1:0]       idx_w;
  logic [CMPW-1:0]       cnt_w;

  ils_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (DATA_WIDTH)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (cnt_q == CW'(CAPACITY));
  assign idx_w      = CMPW'(index_i);
  assign cnt_w      = CMPW'(cnt_q);

  // Sequencer
  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pend_d       = 1'b0;
    kind_d       = kind_q;
    idx_d        = idx_q;
    walk_d       = walk_q;
    left_d       = left_q;
    pend_addr_d  = pend_addr_q;
    val_d        = val_q;
    res_data_d   = res_data_q;
    res_pos_d    = res_pos_q;
    res_found_d  = res_found_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_data_d   = out_data_q;
    out_pos_d    = out_pos_q;
    out_found_d  = out_found_q;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    wr_en        = 1'b0;
    wr_addr      = pend_addr_q;
    wr_data      = rd_data;
    rd_en        = 1'b0;
    rd_addr      = walk_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_data_d   = '0;
          res_pos_d    = '0;
          res_found_d  = 1'b0;
          res_status_d = STATUS_OK;
          val_d        = DATA_WIDTH'(value_i);
          state_d      = S_HOLD;
          unique case (req_e'(req_type_i))
            REQ_APPEND: begin
              // append is an insert at the end with nothing to shift
              if (full) begin
                res_status_d = STATUS_FULL;
              end else begin
                kind_d  = REQ_INSERT;
                idx_d   = AW'(cnt_q);
                left_d  = '0;
                state_d = S_WALK;
              end
            end
            REQ_INSERT: begin
              if (idx_w > cnt_w) begin
                res_status_d = STATUS_RANGE;
              end else if (full) begin
                res_status_d = STATUS_FULL;
              end else begin
                kind_d  = REQ_INSERT;
                idx_d   = AW'(index_i);
                walk_d  = AW'(cnt_q - CW'(1));
                left_d  = cnt_q - CW'(index_i);
                state_d = S_WALK;
              end
            end
            REQ_REMOVE: begin
              if (idx_w >= cnt_w) begin
                res_status_d = STATUS_RANGE;
              end else begin
                kind_d  = REQ_REMOVE;
                idx_d   = AW'(index_i);
                walk_d  = AW'(index_i);
                left_d  = cnt_q - CW'(index_i);
                state_d = S_WALK;
              end
            end
            REQ_READ: begin
              if (idx_w >= cnt_w) begin
                res_status_d = STATUS_RANGE;
              end else begin
                kind_d  = REQ_READ;
                idx_d   = AW'(index_i);
                walk_d  = AW'(index_i);
                left_d  = CW'(1);
                state_d = S_WALK;
              end
            end
            REQ_FIND: begin
              kind_d  = REQ_FIND;
              walk_d  = '0;
              left_d  = cnt_q;
              state_d = S_WALK;
            end
            default: begin
              // unknown kind: zero result, nothing changes
            end
          endcase
        end
      end

      S_WALK: begin
        // issue the next read of the walk
        if (left_q != '0) begin
          rd_en       = 1'b1;
          pend_d      = 1'b1;
          pend_addr_d = walk_q;
          walk_d      = (kind_q == REQ_INSERT) ? walk_q - AW'(1) : walk_q + AW'(1);
          left_d      = left_q - CW'(1);
        end

        // act on the word read last cycle
        if (pend_q) begin
          unique case (kind_q)
            REQ_INSERT: begin
              wr_en   = 1'b1;
              wr_addr = pend_addr_q + AW'(1);
            end
            REQ_REMOVE: begin
              if (pend_addr_q == idx_q) begin
                res_data_d = DATA_OUT_W'(rd_data);
              end else begin
                wr_en   = 1'b1;
                wr_addr = pend_addr_q - AW'(1);
              end
            end
            REQ_READ: begin
              res_data_d = DATA_OUT_W'(rd_data);
            end
            REQ_FIND: begin
              if (rd_data == val_q) begin
                res_found_d = 1'b1;
                res_pos_d   = POS_W'(pend_addr_q);
                pend_d      = 1'b0;
                state_d     = S_HOLD;
              end
            end
            default: begin
            end
          endcase
        end else if (left_q == '0) begin
          // walk done: place inserted word, update count
          state_d = S_HOLD;
          if (kind_q == REQ_INSERT) begin
            wr_en   = 1'b1;
            wr_addr = idx_q;
            wr_data = val_q;
            cnt_d   = cnt_q + CW'(1);
          end else if (kind_q == REQ_REMOVE) begin
            cnt_d   = cnt_q - CW'(1);
          end
        end
      end

      S_HOLD: begin
        // move the result into the output register once it is free
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          out_data_d   = res_data_q;
          out_pos_d    = res_pos_q;
          out_found_d  = res_found_q;
          out_status_d = res_status_q;
          out_count_d  = COUNT_W'(cnt_q);
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      kind_q      <= REQ_APPEND;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      kind_q      <= kind_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    walk_q       <= walk_d;
    left_q       <= left_d;
    pend_addr_q  <= pend_addr_d;
    val_q        <= val_d;
    res_data_q   <= res_data_d;
    res_pos_q    <= res_pos_d;
    res_found_q  <= res_found_d;
    res_status_q <= res_status_d;
    out_data_q   <= out_data_d;
    out_pos_q    <= out_pos_d;
    out_found_q  <= out_found_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o = out_valid_q;
  assign data_o      = out_data_q;
  assign position_o  = out_pos_q;
  assign found_o     = out_found_q;
  assign status_o    = out_status_q;
  assign count_o     = out_count_q;

  // Checks
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_pend_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> state_q == S_WALK)
    else $error("read in flight outside walk");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |=> (cnt_q == $past(cnt_q)))
    else $error("entry count changed on accept");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_found_q) |-> (out_status_q == STATUS_OK))
    else $error("match reported with error status");

endmodule
